/* rtl/tsoc_pkg.sv */
// ----------------------------------------------------------------------------
// tsoc_pkg
// Shared types and constants for the telnet synch output clear block:
// telnet command codes, parser phases, sequencer states and the job record
// handed from the parser to the output sequencer.
// ----------------------------------------------------------------------------
package tsoc_pkg;

  // default sizes
  localparam int HOLD_BYTES_DEF   = 32;
  localparam int BUFFER_BYTES_DEF = 1024;

  // hold fill / flush count width, covers the full hold size range (up to 63)
  localparam int FILL_W  = 6;
  // width of the reported kept count
  localparam int COUNT_W = 11;

  // telnet codes
  localparam logic [7:0] TN_IAC  = 8'hff;
  localparam logic [7:0] TN_DONT = 8'd254;
  localparam logic [7:0] TN_DO   = 8'd253;
  localparam logic [7:0] TN_WONT = 8'd252;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_SB   = 8'd250;
  localparam logic [7:0] TN_EL   = 8'd248;
  localparam logic [7:0] TN_EC   = 8'd247;
  localparam logic [7:0] TN_SE   = 8'd240;

  // parser phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_CMD    = 3'd1,
    PH_OPT    = 3'd2,
    PH_SUB    = 3'd3,
    PH_SUBIAC = 3'd4
  } tsoc_phase_t;

  // output sequencer state
  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_FETCH,
    SQ_FLUSH,
    SQ_TAIL
  } tsoc_seq_state_t;

  // work that one accepted item leaves for the sequencer
  typedef struct packed {
    logic [FILL_W-1:0] flush_cnt;   // held bytes to replay from entry 0
    logic              set_ovf;     // replayed item lost bytes
    logic              has_tail;    // one more result after the replay
    logic              tail_valid;  // tail is a byte, else a bare end marker
    logic [7:0]        tail_byte;
    logic              done;        // item is the buffer's last byte
  } tsoc_job_t;

endpackage

/* rtl/tsoc_if.sv */
// ----------------------------------------------------------------------------
// tsoc channel interfaces
// Valid/ready channels for buffer bytes going in and kept bytes coming out.
// ----------------------------------------------------------------------------

// buffer byte channel
interface tsoc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       already_sent;
  logic       last_byte;

  modport source (output valid, output data_byte, output already_sent,
                  output last_byte, input ready);
  modport sink   (input valid, input data_byte, input already_sent,
                  input last_byte, output ready);
endinterface

// kept byte channel
interface tsoc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        run_end;
  logic        buffer_done;
  logic [10:0] kept_count;
  logic        hold_overflow;

  modport source (output valid, output out_byte, output byte_valid,
                  output run_end, output buffer_done, output kept_count,
                  output hold_overflow, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input run_end, input buffer_done, input kept_count,
                  input hold_overflow, output ready);
endinterface

/* rtl/tsoc_hold_mem.sv */
// ----------------------------------------------------------------------------
// tsoc_hold_mem
// Hold store for the bytes of an item that is still in the sent part.
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tsoc_hold_mem #(
  parameter int HOLD_BYTES = tsoc_pkg::HOLD_BYTES_DEF,
  parameter int AW         = $clog2(HOLD_BYTES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [HOLD_BYTES];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/tsoc_parse.sv */
// ----------------------------------------------------------------------------
// tsoc_parse
// Telnet item parser. Tracks the command phase and the hold fill, writes
// held bytes into the hold store and decides for each item what the
// sequencer has to emit.
// ----------------------------------------------------------------------------
module tsoc_parse #(
  parameter int HOLD_BYTES = tsoc_pkg::HOLD_BYTES_DEF,
  parameter int AW         = $clog2(HOLD_BYTES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          data_byte,
  input  logic                already_sent,
  input  logic                last_byte,
  output tsoc_pkg::tsoc_job_t job,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [7:0]          wr_data
);

  localparam int FW = tsoc_pkg::FILL_W;

  tsoc_pkg::tsoc_phase_t phase_r, phase_nxt, np;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          began_r, began_nxt;
  logic          wanted_r, wanted_nxt;
  logic          lost_r, lost_nxt;

  logic          is_idle;
  logic          ended;
  logic          wanted1;
  logic [FW-1:0] fill0, fill_h;
  logic          lost0, lost_h;
  logic          all_sent;
  logic          decided;
  logic          drop, hold, emit;
  logic          room;
  logic          last_flush;

  // unused phase codes count as outside any command
  assign is_idle = !(phase_r inside {tsoc_pkg::PH_CMD, tsoc_pkg::PH_OPT,
                                     tsoc_pkg::PH_SUB, tsoc_pkg::PH_SUBIAC});

  // phase decode
  always_comb begin
    np      = tsoc_pkg::PH_IDLE;
    ended   = 1'b0;
    wanted1 = is_idle ? 1'b0 : wanted_r;
    case (phase_r)
      tsoc_pkg::PH_CMD: begin
        wanted1 = (data_byte != tsoc_pkg::TN_EC) && (data_byte != tsoc_pkg::TN_EL);
        if (data_byte inside {tsoc_pkg::TN_DO, tsoc_pkg::TN_DONT,
                              tsoc_pkg::TN_WILL, tsoc_pkg::TN_WONT}) begin
          np = tsoc_pkg::PH_OPT;
        end else if (data_byte == tsoc_pkg::TN_SB) begin
          np = tsoc_pkg::PH_SUB;
        end else begin
          ended = 1'b1;
        end
      end
      tsoc_pkg::PH_OPT: begin
        ended = 1'b1;
      end
      tsoc_pkg::PH_SUB: begin
        np = (data_byte == tsoc_pkg::TN_IAC) ? tsoc_pkg::PH_SUBIAC : tsoc_pkg::PH_SUB;
      end
      tsoc_pkg::PH_SUBIAC: begin
        if (data_byte == tsoc_pkg::TN_SE) begin
          ended = 1'b1;
        end else begin
          np = tsoc_pkg::PH_SUB;
        end
      end
      default: begin
        if (data_byte == tsoc_pkg::TN_IAC) begin
          np = tsoc_pkg::PH_CMD;
        end else begin
          ended = 1'b1;
        end
      end
    endcase
  end

  // item bookkeeping, a new item starts with an empty hold
  assign fill0    = is_idle ? '0 : fill_r;
  assign lost0    = is_idle ? 1'b0 : lost_r;
  assign all_sent = is_idle ? already_sent : (began_r & already_sent);
  assign decided  = (np != tsoc_pkg::PH_CMD);

  assign drop = decided && !wanted1;
  assign hold = !drop && (!decided || all_sent);
  assign emit = !drop && !hold;

  // hold store write, bytes past the store are only flagged
  assign room    = (fill0 < FW'(HOLD_BYTES));
  assign wr_en   = acc && hold && room;
  assign wr_addr = fill0[AW-1:0];
  assign wr_data = data_byte;

  always_comb begin
    if (ended) begin
      fill_h = '0;
      lost_h = 1'b0;
    end else begin
      fill_h = room ? fill0 + FW'(1) : fill0;
      lost_h = lost0 | !room;
    end
  end

  // wanted incomplete item held at buffer end is replayed
  assign last_flush = last_byte && hold && (np != tsoc_pkg::PH_IDLE) &&
                      (np != tsoc_pkg::PH_CMD) && wanted1 && (fill_h != '0);

  // job for the sequencer
  always_comb begin
    job            = '0;
    job.done       = last_byte;
    job.tail_valid = emit;
    job.tail_byte  = emit ? data_byte : 8'd0;
    job.has_tail   = emit || (last_byte && !last_flush);
    if (emit) begin
      job.flush_cnt = fill0;
      job.set_ovf   = lost0;
    end else if (last_flush) begin
      job.flush_cnt = fill_h;
      job.set_ovf   = lost_h;
    end
  end

  // next parser state
  always_comb begin
    phase_nxt  = phase_r;
    fill_nxt   = fill_r;
    lost_nxt   = lost_r;
    began_nxt  = began_r;
    wanted_nxt = wanted_r;
    if (acc) begin
      if (last_byte) begin
        phase_nxt  = tsoc_pkg::PH_IDLE;
        fill_nxt   = '0;
        lost_nxt   = 1'b0;
        began_nxt  = 1'b0;
        wanted_nxt = 1'b0;
      end else begin
        phase_nxt  = np;
        fill_nxt   = hold ? fill_h : '0;
        lost_nxt   = hold ? lost_h : 1'b0;
        began_nxt  = all_sent;
        wanted_nxt = wanted1;
      end
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= tsoc_pkg::PH_IDLE;
      fill_r   <= '0;
      lost_r   <= 1'b0;
      began_r  <= 1'b0;
      wanted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      fill_r   <= fill_nxt;
      lost_r   <= lost_nxt;
      began_r  <= began_nxt;
      wanted_r <= wanted_nxt;
    end
  end

endmodule

/* rtl/tsoc_seq.sv */
// ----------------------------------------------------------------------------
// tsoc_seq
// Output sequencer. Takes each accepted item's job, replays held bytes from
// the hold store one per cycle unless stalled, appends the direct byte or end
// marker, keeps the kept count and overflow flag, drives the output register.
// ----------------------------------------------------------------------------
module tsoc_seq #(
  parameter int HOLD_BYTES   = tsoc_pkg::HOLD_BYTES_DEF,
  parameter int BUFFER_BYTES = tsoc_pkg::BUFFER_BYTES_DEF,
  parameter int AW           = $clog2(HOLD_BYTES)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tsoc_pkg::tsoc_job_t               job,
  output logic                              rd_en,
  output logic [AW-1:0]                     rd_addr,
  input  logic [7:0]                        rd_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_byte,
  output logic                              byte_valid,
  output logic                              run_end,
  output logic                              buffer_done,
  output logic [tsoc_pkg::COUNT_W-1:0]      kept_count,
  output logic                              hold_overflow
);

  localparam int FW = tsoc_pkg::FILL_W;
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int KW = (CW > tsoc_pkg::COUNT_W) ? CW : tsoc_pkg::COUNT_W;

  tsoc_pkg::tsoc_seq_state_t state_r, state_nxt;

  logic [FW-1:0] idx_r, left_r, idx_inc;
  logic          has_tail_r, tail_valid_r, done_r;
  logic [7:0]    tail_byte_r;

  logic [KW-1:0] kept_r, kept_nxt, kept_inc;
  logic          ovf_r, ovf_nxt;

  logic                          out_vld_r;
  logic [7:0]                    out_byte_r;
  logic                          out_bv_r, out_re_r, out_bd_r, out_ovf_r;
  logic [tsoc_pkg::COUNT_W-1:0]  out_cnt_r;

  logic       acc, slot_free, last_ent;
  logic       ld, ld_bv, ld_re, ld_bd;
  logic [7:0] ld_byte;

  assign in_ready  = (state_r == tsoc_pkg::SQ_IDLE);
  assign acc       = in_valid && in_ready;
  assign slot_free = !out_vld_r || out_ready;
  assign last_ent  = (left_r == FW'(1));
  assign idx_inc   = idx_r + FW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsoc_pkg::SQ_IDLE: begin
        if (acc) begin
          if (job.flush_cnt != '0) begin
            state_nxt = tsoc_pkg::SQ_FETCH;
          end else if (job.has_tail && !slot_free) begin
            state_nxt = tsoc_pkg::SQ_TAIL;
          end
        end
      end
      tsoc_pkg::SQ_FETCH: begin
        state_nxt = tsoc_pkg::SQ_FLUSH;
      end
      tsoc_pkg::SQ_FLUSH: begin
        if (slot_free && last_ent) begin
          state_nxt = has_tail_r ? tsoc_pkg::SQ_TAIL : tsoc_pkg::SQ_IDLE;
        end
      end
      tsoc_pkg::SQ_TAIL: begin
        if (slot_free) begin
          state_nxt = tsoc_pkg::SQ_IDLE;
        end
      end
      default: begin
        state_nxt = tsoc_pkg::SQ_IDLE;
      end
    endcase
  end

  // memory reads and output register loads
  always_comb begin
    ld      = 1'b0;
    ld_byte = 8'd0;
    ld_bv   = 1'b0;
    ld_re   = 1'b0;
    ld_bd   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = idx_r[AW-1:0];
    case (state_r)
      tsoc_pkg::SQ_IDLE: begin
        if (acc && (job.flush_cnt == '0) && job.has_tail && slot_free) begin
          ld      = 1'b1;
          ld_byte = job.tail_byte;
          ld_bv   = job.tail_valid;
          ld_re   = 1'b1;
          ld_bd   = job.done;
        end
      end
      tsoc_pkg::SQ_FETCH: begin
        rd_en = 1'b1;
      end
      tsoc_pkg::SQ_FLUSH: begin
        if (slot_free) begin
          ld      = 1'b1;
          ld_byte = rd_data;
          ld_bv   = 1'b1;
          ld_re   = last_ent && !has_tail_r;
          ld_bd   = last_ent && !has_tail_r && done_r;
          if (!last_ent) begin
            rd_en   = 1'b1;
            rd_addr = idx_inc[AW-1:0];
          end
        end
      end
      tsoc_pkg::SQ_TAIL: begin
        if (slot_free) begin
          ld      = 1'b1;
          ld_byte = tail_byte_r;
          ld_bv   = tail_valid_r;
          ld_re   = 1'b1;
          ld_bd   = done_r;
        end
      end
      default: ;
    endcase
  end

  // kept count saturates at the buffer size, clears after the buffer
  assign kept_inc = (ld_bv && (kept_r < KW'(BUFFER_BYTES))) ? kept_r + KW'(1) : kept_r;

  always_comb begin
    kept_nxt = kept_r;
    ovf_nxt  = ovf_r;
    if (ld) begin
      kept_nxt = ld_bd ? '0 : kept_inc;
    end
    if (ld && ld_bd) begin
      ovf_nxt = 1'b0;
    end else if (acc && job.set_ovf) begin
      ovf_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tsoc_pkg::SQ_IDLE;
      kept_r    <= '0;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      kept_r    <= kept_nxt;
      ovf_r     <= ovf_nxt;
      out_vld_r <= ld || (out_vld_r && !out_ready);
    end
  end

  // job registers
  always_ff @(posedge clk) begin
    if (acc) begin
      idx_r        <= '0;
      left_r       <= job.flush_cnt;
      has_tail_r   <= job.has_tail;
      tail_valid_r <= job.tail_valid;
      tail_byte_r  <= job.tail_byte;
      done_r       <= job.done;
    end else if (ld && (state_r == tsoc_pkg::SQ_FLUSH)) begin
      idx_r  <= idx_inc;
      left_r <= left_r - FW'(1);
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (ld) begin
      out_byte_r <= ld_byte;
      out_bv_r   <= ld_bv;
      out_re_r   <= ld_re;
      out_bd_r   <= ld_bd;
      out_cnt_r  <= kept_inc[tsoc_pkg::COUNT_W-1:0];
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_byte      = out_byte_r;
  assign byte_valid    = out_bv_r;
  assign run_end       = out_re_r;
  assign buffer_done   = out_bd_r;
  assign kept_count    = out_cnt_r;
  assign hold_overflow = out_ovf_r;

endmodule

/* rtl/telnet_synch_output_clear.sv */
// ----------------------------------------------------------------------------
// telnet_synch_output_clear
// Clears a pending telnet output buffer down to the commands it must keep.
//
// Input channel in_chan takes one buffer byte per item with its sent flag and
// last-byte flag. Output channel out_chan gives the kept bytes in order, one
// per item; the last result of each input item carries run_end, and the last
// result of the buffer carries buffer_done and the kept count. A buffer whose
// last byte keeps nothing still gives one bare end marker.
// Throughput: one input item per cycle while bytes are dropped, held or
// passed straight through. The first item of a wanted command past its sent
// part, once the command is known, replays the N held bytes of that command
// (at least its IAC) and then gives its own byte: the sequencer first starts
// the hold store read, gives one byte per cycle out of its single read port
// while the output register is free, then the item's own byte, and takes the
// next item only after that. A wanted incomplete command replayed at the
// buffer end has no own byte. A direct result goes from the accepted item
// into the output register, or waits in the sequencer while that is full.
// Reset: parser returns to outside any command, counters clear; the hold
// store needs no clearing pass. A stalled receiver holds the output register;
// items that give no result are still taken, and the next item with a result
// waits in the sequencer and holds off the input until the register frees.
// ----------------------------------------------------------------------------
module telnet_synch_output_clear #(
  parameter int HOLD_BYTES   = tsoc_pkg::HOLD_BYTES_DEF,
  parameter int BUFFER_BYTES = tsoc_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tsoc_in_if.sink     in_chan,
  tsoc_out_if.source  out_chan
);

  localparam int AW = $clog2(HOLD_BYTES);

  tsoc_pkg::tsoc_job_t job;
  logic                in_acc;
  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [7:0]          wr_data, rd_data;

  // item accepted
  assign in_acc = in_chan.valid && in_chan.ready;

  // parser
  tsoc_parse #(
    .HOLD_BYTES (HOLD_BYTES),
    .AW         (AW)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .data_byte    (in_chan.data_byte),
    .already_sent (in_chan.already_sent),
    .last_byte    (in_chan.last_byte),
    .job          (job),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  // hold store; writes only on accept, reads only while replaying
  tsoc_hold_mem #(
    .HOLD_BYTES (HOLD_BYTES),
    .AW         (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output sequencer
  tsoc_seq #(
    .HOLD_BYTES   (HOLD_BYTES),
    .BUFFER_BYTES (BUFFER_BYTES),
    .AW           (AW)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_chan.valid),
    .in_ready      (in_chan.ready),
    .job           (job),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_byte      (out_chan.out_byte),
    .byte_valid    (out_chan.byte_valid),
    .run_end       (out_chan.run_end),
    .buffer_done   (out_chan.buffer_done),
    .kept_count    (out_chan.kept_count),
    .hold_overflow (out_chan.hold_overflow)
  );

endmodule

/* rtl/tsoc_checker.sv */
// ----------------------------------------------------------------------------
// tsoc_checker
// Port-level checks for telnet_synch_output_clear, bound to the top level.
// ----------------------------------------------------------------------------
module tsoc_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic byte_valid,
  input logic run_end,
  input logic buffer_done
);

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // a bare end marker only closes a buffer
  a_marker_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> buffer_done && run_end)
    else $error("bare end marker not at buffer end");

  // buffer end is always the end of an item's results
  a_done_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && buffer_done |-> run_end)
    else $error("buffer_done without run_end");

  // results of one item follow without gaps
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !run_end |=> out_valid)
    else $error("gap inside the results of one item");

endmodule

bind telnet_synch_output_clear tsoc_checker u_tsoc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .byte_valid  (out_chan.byte_valid),
  .run_end     (out_chan.run_end),
  .buffer_done (out_chan.buffer_done)
);
